FILE: rtl/multichannel_adc_serial_deinterleaver_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deinterleaver core
// Shared property forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ADC_SERIAL_DEINTERLEAVER_CORE_DEFINES_SVH
`define MULTICHANNEL_ADC_SERIAL_DEINTERLEAVER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCAD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mcad_pkg.sv
// ----------------------------------------------------------------------------
// mcad_pkg
// Constants shared by the deinterleaver core and its checker.
// ----------------------------------------------------------------------------
package mcad_pkg;

    localparam int NUM_LINES      = 4;
    localparam int PIN_W          = 8;
    localparam int CHAN_W         = 3;
    localparam int OUT_SAMPLE_W   = 24;
    localparam int SKIP_W         = 8;
    localparam int M_TDATA_W      = 32;
    localparam int LINE_IDX_W     = 2;
    localparam int PEND_W         = 3;

    localparam logic [SKIP_W-1:0]     MAX_SKIP_RESET = 8'd32;
    localparam logic [LINE_IDX_W-1:0] LAST_LINE      = 2'd3;
    localparam logic [PEND_W-1:0]     PEND_FRAME     = 3'd4;
    localparam logic [PEND_W-1:0]     PEND_ONE       = 3'd1;
    localparam logic [PEND_W-1:0]     PEND_NONE      = 3'd0;

    typedef logic [OUT_SAMPLE_W-1:0] sample_t;

endpackage

FILE: rtl/multichannel_adc_serial_deinterleaver_core.sv
// ----------------------------------------------------------------------------
// multichannel_adc_serial_deinterleaver_core
// Splits four left-justified serial ADC data lines into eight channel samples.
// ----------------------------------------------------------------------------
// One sampled pin byte is taken per clock while s_tready is high (bit 0 the
// left/right clock, bits 1 to 4 the data lines). A frame collects SAMPLE_BITS
// bits per line, LSB first, into four shift registers. The byte that ends a
// frame loads all four samples into an output bank at once, and they leave
// it one per cycle while m_tready is high, from the next cycle on; the fourth
// is marked with tlast. The only stall comes from the output bank: a byte
// that could finish a frame or raise a sync error waits while an earlier
// result is pending, unless it is the only one and is taken in that cycle.
// Other bytes are taken even while a burst drains. Too many same-level
// bytes after a frame give one result with tuser set and resynchronise.
// ----------------------------------------------------------------------------
module multichannel_adc_serial_deinterleaver_core
    import mcad_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: max_skip.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SKIP_W-1:0]     cfg_data,
    // [7:0] pin_byte
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIN_W-1:0]      s_tdata,
    // [2:0] channel, [26:3] sample, [31:27] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    // [0] sync_error
    output logic                  m_tuser
);

    localparam int BIT_W = $clog2(SAMPLE_BITS);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SAMPLE_BITS - 1);

    // Frame state.
    logic               collecting_reg, collecting_next;
    logic               level_reg, level_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [SKIP_W-1:0]  max_skip_reg;
    logic [SAMPLE_BITS-1:0] acc_reg  [NUM_LINES];
    logic [SAMPLE_BITS-1:0] acc_next [NUM_LINES];

    // Output bank.
    sample_t             bank_reg [NUM_LINES];
    logic                bank_level_reg;
    logic                err_reg;
    logic [LINE_IDX_W-1:0] rd_reg;
    logic [PEND_W-1:0]   pend_reg;

    logic accept, may_emit, emit_frame, emit_err, take_byte, pin_level;
    sample_t frame_samples [NUM_LINES];

    assign cfg_ready = 1'b1;
    assign pin_level = s_tdata[0];

    // A byte can only produce results at the last bit of a frame or when the
    // skip budget is spent.
    assign may_emit = (collecting_reg && (bit_reg == LAST_BIT)) ||
                      (!collecting_reg && (skip_reg >= max_skip_reg));
    assign s_tready = !may_emit || (pend_reg == PEND_NONE) ||
                      ((pend_reg == PEND_ONE) && m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        collecting_next = collecting_reg;
        level_next      = level_reg;
        bit_next        = bit_reg;
        skip_next       = skip_reg;
        emit_frame      = 1'b0;
        emit_err        = 1'b0;
        take_byte       = 1'b0;
        if (collecting_reg) begin
            take_byte = 1'b1;
        end else if (pin_level == level_reg) begin
            if (skip_reg >= max_skip_reg) begin
                emit_err        = 1'b1;
                collecting_next = 1'b1;
                level_next      = 1'b0;
                bit_next        = '0;
                skip_next       = '0;
            end else begin
                skip_next = skip_reg + 1'b1;
            end
        end else begin
            take_byte = 1'b1;
            bit_next  = '0;
        end
        if (take_byte) begin
            if (bit_next == '0) begin
                level_next = pin_level;
            end
            if (bit_next == LAST_BIT) begin
                emit_frame      = 1'b1;
                bit_next        = '0;
                collecting_next = 1'b0;
                skip_next       = '0;
            end else begin
                bit_next        = bit_next + 1'b1;
                collecting_next = 1'b1;
                skip_next       = '0;
            end
        end
    end

    // Each line shifts in from the top, so after a full frame the first bit
    // sits at bit 0 and no clearing is needed between frames.
    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            acc_next[k] = {s_tdata[k+1], acc_reg[k][SAMPLE_BITS-1:1]};
        end
    end

    generate
        if (SAMPLE_BITS >= OUT_SAMPLE_W) begin : g_wide
            always_comb begin
                for (int k = 0; k < NUM_LINES; k++) begin
                    frame_samples[k] = acc_next[k][OUT_SAMPLE_W-1:0];
                end
            end
        end else begin : g_narrow
            always_comb begin
                for (int k = 0; k < NUM_LINES; k++) begin
                    frame_samples[k] = OUT_SAMPLE_W'(acc_next[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b1;
            level_reg      <= 1'b0;
            bit_reg        <= '0;
            skip_reg       <= '0;
            max_skip_reg   <= MAX_SKIP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_skip_reg <= cfg_data;
            end
            if (accept) begin
                collecting_reg <= collecting_next;
                level_reg      <= level_next;
                bit_reg        <= bit_next;
                skip_reg       <= skip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && take_byte) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    // Output bank control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
            rd_reg   <= '0;
            err_reg  <= 1'b0;
        end else if (accept && (emit_frame || emit_err)) begin
            pend_reg <= emit_frame ? PEND_FRAME : PEND_ONE;
            rd_reg   <= '0;
            err_reg  <= emit_err;
        end else if (m_tvalid && m_tready) begin
            pend_reg <= pend_reg - 1'b1;
            rd_reg   <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit_frame) begin
            bank_level_reg <= level_next;
            for (int k = 0; k < NUM_LINES; k++) begin
                bank_reg[k] <= frame_samples[k];
            end
        end
    end

    assign m_tvalid = (pend_reg != PEND_NONE);
    assign m_tuser  = err_reg;
    assign m_tlast  = err_reg || (rd_reg == LAST_LINE);
    // Channel is 2*line+1 at level 0 and 2*line at level 1.
    assign m_tdata  = err_reg ? '0 :
                      M_TDATA_W'({bank_reg[rd_reg], rd_reg, ~bank_level_reg});

endmodule

FILE: rtl/mcad_checker.sv
// ----------------------------------------------------------------------------
// mcad_checker
// Port-level checks on the deinterleaver core's result stream.
// ----------------------------------------------------------------------------
`include "multichannel_adc_serial_deinterleaver_core_defines.svh"

module mcad_checker
    import mcad_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    // A stalled transaction keeps its contents.
    `MCAD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")

    // An error result is a lone, zeroed, last transaction.
    `MCAD_ASSERT_SAME(a_err_shape, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "malformed sync error result")

    // The last sample of a frame always comes from the fourth data line.
    `MCAD_ASSERT_SAME(a_last_line, m_tvalid && m_tlast && !m_tuser, m_tdata[2:1] == 2'b11, "frame ended on the wrong line")

    // A frame burst runs without gaps until its last sample.
    `MCAD_ASSERT_NEXT(a_burst, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a frame burst")

endmodule

bind multichannel_adc_serial_deinterleaver_core mcad_checker u_mcad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
